// ===== rtl/core/bhds_pkg.sv =====
// ----------------------------------------------------------------------------
// bhds_pkg
// types, register indexes, frame constants and reset values shared by the
// brake hold diagnostic sequencer modules
// ----------------------------------------------------------------------------
package bhds_pkg;

    // event kinds carried in the input tuser
    typedef enum logic [2:0] {
        KIND_FORCE   = 3'd0,
        KIND_RELEASE = 3'd1,
        KIND_RPM     = 3'd2,
        KIND_TICK    = 3'd3,
        KIND_LAUNCH  = 3'd4
    } kind_t;

    // hold sequence modes
    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_RELEASE = 3'd1,
        MODE_SESSION = 3'd2,
        MODE_TESTER  = 3'd3,
        MODE_IO      = 3'd4
    } hold_mode_t;

    // configuration port
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_ENABLE   = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_TORQUE   = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_STALL    = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_INTERVAL = 8'd3;

    localparam logic [14:0] TORQUE_LIMIT_RESET = 15'd100;
    localparam logic [15:0] STALL_RPM_RESET    = 16'd400;
    localparam logic [15:0] INTERVAL_RESET     = 16'd500;

    // fixed bus target, frames always go to this extended id
    localparam logic [31:0] FRAME_CAN_ID = 32'h18DA_28F1;

    // frame bytes, byte 0 in the low bits
    localparam logic [63:0] PAYLOAD_RELEASE = 64'h0000_0000_BD5A_2F04;
    localparam logic [63:0] PAYLOAD_SESSION = 64'h0000_0000_0040_1002;
    localparam logic [63:0] PAYLOAD_TESTER  = 64'h0000_0000_0080_3E02;
    localparam logic [63:0] PAYLOAD_IO      = 64'h0310_2703_BD5A_2F07;

    localparam logic [3:0] LEN_RELEASE = 4'd5;
    localparam logic [3:0] LEN_SESSION = 4'd3;
    localparam logic [3:0] LEN_TESTER  = 4'd3;
    localparam logic [3:0] LEN_IO      = 4'd8;

    // stream widths
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 104;

    typedef struct packed {
        logic        feature_enable;
        logic [14:0] launch_torque_limit;
        logic [15:0] stall_rpm_limit;
        logic [15:0] send_interval_ms;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic               vehicle_stopped;
        logic               dyno_mode;
        logic [15:0]        engine_rpm;
        logic signed [15:0] torque_value;
        logic [31:0]        time_now;
    } item_t;

    typedef struct packed {
        hold_mode_t  hold_mode;
        logic        launch_assist;
        logic [31:0] last_send_time;
        logic        last_send_valid;
        logic [31:0] frames_sent;
    } state_t;

    typedef struct packed {
        logic        force_accepted;
        logic        frame_valid;
        logic [3:0]  frame_length;
        logic [63:0] frame_payload;
        logic [31:0] frame_time;
        logic        release_due;
    } result_t;

endpackage

// ===== rtl/core/bhds_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bhds_cfg_regs
// configuration register file, written through a valid/ready channel
// ----------------------------------------------------------------------------
module bhds_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bhds_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [bhds_pkg::CFG_DATA_W-1:0]  cfg_data,
    output bhds_pkg::cfg_t                   cfg
);

    bhds_pkg::cfg_t cfg_reg;
    bhds_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_addr)
                bhds_pkg::CFG_IDX_ENABLE:   cfg_next.feature_enable      = cfg_data[0];
                bhds_pkg::CFG_IDX_TORQUE:   cfg_next.launch_torque_limit = cfg_data[14:0];
                bhds_pkg::CFG_IDX_STALL:    cfg_next.stall_rpm_limit     = cfg_data;
                bhds_pkg::CFG_IDX_INTERVAL: cfg_next.send_interval_ms    = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.feature_enable      <= 1'b0;
            cfg_reg.launch_torque_limit <= bhds_pkg::TORQUE_LIMIT_RESET;
            cfg_reg.stall_rpm_limit     <= bhds_pkg::STALL_RPM_RESET;
            cfg_reg.send_interval_ms    <= bhds_pkg::INTERVAL_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/bhds_step.sv =====
// ----------------------------------------------------------------------------
// bhds_step
// event decode: next sequencer state and the result for one event
// ----------------------------------------------------------------------------
module bhds_step (
    input  bhds_pkg::cfg_t    cfg,
    input  bhds_pkg::state_t  state,
    input  bhds_pkg::item_t   item,
    output bhds_pkg::state_t  state_next,
    output bhds_pkg::result_t result
);

    logic        active;
    logic [31:0] elapsed;
    logic        too_early;

    assign active    = (state.hold_mode != bhds_pkg::MODE_NORMAL);
    assign elapsed   = item.time_now - state.last_send_time;
    assign too_early = state.last_send_valid && (elapsed <= {16'd0, cfg.send_interval_ms});

    always_comb begin
        state_next = state;
        result     = '0;
        unique case (item.kind)
            bhds_pkg::KIND_FORCE: begin
                if (cfg.feature_enable && item.vehicle_stopped && item.dyno_mode && !active) begin
                    state_next.hold_mode       = bhds_pkg::MODE_SESSION;
                    state_next.launch_assist   = 1'b1;
                    state_next.last_send_valid = 1'b0;
                    result.force_accepted      = 1'b1;
                end
            end
            bhds_pkg::KIND_RELEASE, bhds_pkg::KIND_RPM: begin
                if (active && ((item.kind == bhds_pkg::KIND_RELEASE) ||
                               (item.engine_rpm < cfg.stall_rpm_limit))) begin
                    state_next.hold_mode       = bhds_pkg::MODE_RELEASE;
                    state_next.launch_assist   = 1'b0;
                    state_next.last_send_valid = 1'b0;
                end
            end
            bhds_pkg::KIND_TICK: begin
                if (cfg.feature_enable && !too_early) begin
                    // modes outside the sequence send nothing
                    unique case (state.hold_mode)
                        bhds_pkg::MODE_RELEASE: begin
                            result.frame_valid    = 1'b1;
                            result.frame_length   = bhds_pkg::LEN_RELEASE;
                            result.frame_payload  = bhds_pkg::PAYLOAD_RELEASE;
                            state_next.hold_mode  = bhds_pkg::MODE_NORMAL;
                        end
                        bhds_pkg::MODE_SESSION: begin
                            result.frame_valid    = 1'b1;
                            result.frame_length   = bhds_pkg::LEN_SESSION;
                            result.frame_payload  = bhds_pkg::PAYLOAD_SESSION;
                            state_next.hold_mode  = bhds_pkg::MODE_TESTER;
                        end
                        bhds_pkg::MODE_TESTER: begin
                            result.frame_valid    = 1'b1;
                            result.frame_length   = bhds_pkg::LEN_TESTER;
                            result.frame_payload  = bhds_pkg::PAYLOAD_TESTER;
                            state_next.hold_mode  = bhds_pkg::MODE_IO;
                        end
                        bhds_pkg::MODE_IO: begin
                            result.frame_valid    = 1'b1;
                            result.frame_length   = bhds_pkg::LEN_IO;
                            result.frame_payload  = bhds_pkg::PAYLOAD_IO;
                            state_next.hold_mode  = bhds_pkg::MODE_TESTER;
                        end
                        default: ;
                    endcase
                    if (result.frame_valid) begin
                        result.frame_time          = item.time_now;
                        state_next.last_send_time  = item.time_now;
                        state_next.last_send_valid = 1'b1;
                        state_next.frames_sent     = state.frames_sent + 32'd1;
                    end
                end
            end
            bhds_pkg::KIND_LAUNCH: begin
                if (state.launch_assist && active &&
                    (item.torque_value >= $signed({1'b0, cfg.launch_torque_limit}))) begin
                    result.release_due = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/core/brake_hold_diag_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// brake_hold_diag_sequencer_core
// brake hold diagnostic frame sequencer with stream ports
// ----------------------------------------------------------------------------
// Each event on the slave stream gives exactly one result on the master
// stream. The block takes one event per clock while results are taken; an
// event passes an input register and the decode logic and lands in the
// result register, from which its result is presented on the master stream.
// The sequencer state (mode, launch assist, last send time, sent count) is
// updated in the same edge that loads the result register, so back to back
// events see each other's effect. A waiting result holds the input register,
// which still takes one more event before s_tready drops. All frames go to
// the fixed extended id 0x18DA28F1 on one bus, so neither the bus nor the id
// is a port.
// Configuration writes are always taken (cfg_ready is tied high) and must
// only be issued while the block is idle.
// ----------------------------------------------------------------------------
module brake_hold_diag_sequencer_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bhds_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [bhds_pkg::CFG_DATA_W-1:0]     cfg_data,
    // event stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // vehicle_stopped[0], dyno_mode[1], engine_rpm[17:2], torque_value[33:18],
    // time_now[65:34], zero fill[71:66]
    input  logic [bhds_pkg::S_TDATA_W-1:0]      s_tdata,
    // kind[2:0]
    input  logic [2:0]                          s_tuser,
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // force_accepted[0], frame_valid[1], frame_length[5:2], frame_payload[69:6],
    // frame_time[101:70], release_due[102], zero fill[103]
    output logic [bhds_pkg::M_TDATA_W-1:0]      m_tdata
);

    bhds_pkg::cfg_t    cfg;
    bhds_pkg::item_t   item_in;
    bhds_pkg::item_t   item_reg;
    logic              in_valid_reg;
    bhds_pkg::state_t  state_reg;
    bhds_pkg::state_t  state_next;
    bhds_pkg::result_t result_next;
    bhds_pkg::result_t result_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              advance;

    // configuration registers
    bhds_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // unpack the incoming request
    always_comb begin
        item_in.kind            = s_tuser;
        item_in.vehicle_stopped = s_tdata[0];
        item_in.dyno_mode       = s_tdata[1];
        item_in.engine_rpm      = s_tdata[17:2];
        item_in.torque_value    = s_tdata[33:18];
        item_in.time_now        = s_tdata[65:34];
    end

    // the registered event moves on when the result register is free or emptying
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // payload register, no reset
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= item_in;
        end
    end

    // event decode
    bhds_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // sequencer state commits together with the result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.hold_mode       <= bhds_pkg::MODE_NORMAL;
            state_reg.launch_assist   <= 1'b0;
            state_reg.last_send_time  <= 32'd0;
            state_reg.last_send_valid <= 1'b0;
            state_reg.frames_sent     <= 32'd0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_comb begin
        priority if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    // pack the result
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       result_reg.release_due,
                       result_reg.frame_time,
                       result_reg.frame_payload,
                       result_reg.frame_length,
                       result_reg.frame_valid,
                       result_reg.force_accepted};

    // a stalled input register always means a result is waiting downstream
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a waiting result");

    // an accepted force leaves the sequence at session start until the next event
    a_force_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && result_reg.force_accepted) |->
        (state_reg.hold_mode == bhds_pkg::MODE_SESSION && state_reg.launch_assist))
        else $error("force accepted but sequence not at session start");

    // a shown frame matches the pacing state it left behind
    a_frame_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && result_reg.frame_valid) |->
        (state_reg.last_send_valid && state_reg.last_send_time == result_reg.frame_time &&
         (result_reg.frame_length == bhds_pkg::LEN_SESSION ||
          result_reg.frame_length == bhds_pkg::LEN_RELEASE ||
          result_reg.frame_length == bhds_pkg::LEN_IO)))
        else $error("frame result inconsistent with pacing state");

    // no frame fields without a frame
    a_frame_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !result_reg.frame_valid) |->
        (result_reg.frame_length == 4'd0 && result_reg.frame_payload == 64'd0 &&
         result_reg.frame_time == 32'd0))
        else $error("frame fields set without a frame");

    // launch release is only reported while launch assist is held
    a_release_due: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && result_reg.release_due) |->
        (state_reg.launch_assist && state_reg.hold_mode != bhds_pkg::MODE_NORMAL))
        else $error("release due without launch assist");

endmodule

// ===== bench/bhds_result_monitor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bhds_result_monitor
// watches the register, event and result channels of the brake hold
// sequencer, keeps its own model of the hold sequence, and checks each
// result against the oldest outstanding prediction
// ----------------------------------------------------------------------------
module bhds_result_monitor (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [bhds_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [bhds_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [bhds_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [2:0]                      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [bhds_pkg::M_TDATA_W-1:0]  m_tdata,
    output int                              fail_count,
    output int                              pending,
    output int                              results_seen,
    output int                              frames_seen
);

    bhds_pkg::cfg_t       regs;
    bhds_pkg::hold_mode_t mode;
    logic                 assist;
    logic [31:0]          last_time;
    logic                 last_valid;
    logic [31:0]          sent_count;
    bhds_pkg::result_t    due_results[$];

    // advances the hold sequence by one request and returns its result
    function automatic bhds_pkg::result_t step_hold_sequencer(input bhds_pkg::item_t ev);
        bhds_pkg::result_t res;
        logic [31:0]       elapsed;
        res = '0;
        case (bhds_pkg::kind_t'(ev.kind))
            bhds_pkg::KIND_FORCE: begin
                if (regs.feature_enable && ev.vehicle_stopped && ev.dyno_mode &&
                    mode == bhds_pkg::MODE_NORMAL) begin
                    mode = bhds_pkg::MODE_SESSION;
                    assist = 1'b1;
                    last_valid = 1'b0;
                    res.force_accepted = 1'b1;
                end
            end
            bhds_pkg::KIND_RELEASE, bhds_pkg::KIND_RPM: begin
                if (mode != bhds_pkg::MODE_NORMAL && (ev.kind == bhds_pkg::KIND_RELEASE ||
                    ev.engine_rpm < regs.stall_rpm_limit)) begin
                    mode = bhds_pkg::MODE_RELEASE;
                    assist = 1'b0;
                    last_valid = 1'b0;
                end
            end
            bhds_pkg::KIND_TICK: begin
                elapsed = ev.time_now - last_time;
                if (regs.feature_enable &&
                    !(last_valid && elapsed <= {16'd0, regs.send_interval_ms})) begin
                    res.frame_valid = 1'b1;
                    case (mode)
                        bhds_pkg::MODE_RELEASE: begin
                            res.frame_length  = bhds_pkg::LEN_RELEASE;
                            res.frame_payload = bhds_pkg::PAYLOAD_RELEASE;
                            mode = bhds_pkg::MODE_NORMAL;
                        end
                        bhds_pkg::MODE_SESSION: begin
                            res.frame_length  = bhds_pkg::LEN_SESSION;
                            res.frame_payload = bhds_pkg::PAYLOAD_SESSION;
                            mode = bhds_pkg::MODE_TESTER;
                        end
                        bhds_pkg::MODE_TESTER: begin
                            res.frame_length  = bhds_pkg::LEN_TESTER;
                            res.frame_payload = bhds_pkg::PAYLOAD_TESTER;
                            mode = bhds_pkg::MODE_IO;
                        end
                        bhds_pkg::MODE_IO: begin
                            res.frame_length  = bhds_pkg::LEN_IO;
                            res.frame_payload = bhds_pkg::PAYLOAD_IO;
                            mode = bhds_pkg::MODE_TESTER;
                        end
                        default: res.frame_valid = 1'b0;
                    endcase
                    if (res.frame_valid) begin
                        res.frame_time = ev.time_now;
                        last_time  = ev.time_now;
                        last_valid = 1'b1;
                        sent_count = sent_count + 32'd1;
                    end
                end
            end
            bhds_pkg::KIND_LAUNCH: begin
                res.release_due = assist && mode != bhds_pkg::MODE_NORMAL &&
                    ($signed({ev.torque_value[15], ev.torque_value}) >=
                     $signed({2'b00, regs.launch_torque_limit}));
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch
        bhds_pkg::item_t   ev;
        bhds_pkg::result_t got;
        bhds_pkg::result_t want;
        if (!aresetn) begin
            regs.feature_enable      = 1'b0;
            regs.launch_torque_limit = bhds_pkg::TORQUE_LIMIT_RESET;
            regs.stall_rpm_limit     = bhds_pkg::STALL_RPM_RESET;
            regs.send_interval_ms    = bhds_pkg::INTERVAL_RESET;
            mode       = bhds_pkg::MODE_NORMAL;
            assist     = 1'b0;
            last_time  = '0;
            last_valid = 1'b0;
            sent_count = '0;
            due_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    bhds_pkg::CFG_IDX_ENABLE:   regs.feature_enable      = cfg_data[0];
                    bhds_pkg::CFG_IDX_TORQUE:   regs.launch_torque_limit = cfg_data[14:0];
                    bhds_pkg::CFG_IDX_STALL:    regs.stall_rpm_limit     = cfg_data;
                    bhds_pkg::CFG_IDX_INTERVAL: regs.send_interval_ms    = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                ev.kind            = s_tuser;
                ev.vehicle_stopped = s_tdata[0];
                ev.dyno_mode       = s_tdata[1];
                ev.engine_rpm      = s_tdata[17:2];
                ev.torque_value    = s_tdata[33:18];
                ev.time_now        = s_tdata[65:34];
                due_results.push_back(step_hold_sequencer(ev));
            end
            if (m_tvalid && m_tready) begin
                got.force_accepted = m_tdata[0];
                got.frame_valid    = m_tdata[1];
                got.frame_length   = m_tdata[5:2];
                got.frame_payload  = m_tdata[69:6];
                got.frame_time     = m_tdata[101:70];
                got.release_due    = m_tdata[102];
                if (due_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual %0h",
                             $time, m_tdata);
                end else begin
                    want = due_results.pop_front();
                    compare_field("force_accepted", 64'(want.force_accepted),
                                  64'(got.force_accepted));
                    compare_field("frame_valid", 64'(want.frame_valid),
                                  64'(got.frame_valid));
                    compare_field("frame_length", 64'(want.frame_length),
                                  64'(got.frame_length));
                    compare_field("frame_payload", want.frame_payload, got.frame_payload);
                    compare_field("frame_time", 64'(want.frame_time), 64'(got.frame_time));
                    compare_field("release_due", 64'(want.release_due),
                                  64'(got.release_due));
                    results_seen++;
                    if (want.frame_valid)
                        frames_seen++;
                end
            end
        end
        pending = due_results.size();
    end

endmodule

// ===== bench/brake_hold_diag_sequencer_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// brake_hold_diag_sequencer_core_tb
// drives directed and random hold sequences into the brake hold sequencer
// under several register settings, with bursty requests and a stalling
// result receiver; checking is done by bhds_result_monitor
// ----------------------------------------------------------------------------
module brake_hold_diag_sequencer_core_tb;

    localparam int REQUEST_GOAL = 850;   // active requests in the random part
    localparam int PHASES       = 8;     // register settings in the random part
    localparam logic [bhds_pkg::CFG_ADDR_W-1:0] CFG_IDX_SPARE = 8'd4;   // no register here

    // receiver stall styles
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_style_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [bhds_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [bhds_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [bhds_pkg::S_TDATA_W-1:0]  s_tdata;
    logic [2:0]                      s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [bhds_pkg::M_TDATA_W-1:0]  m_tdata;

    int fail_count;
    int pending;
    int results_seen;
    int frames_seen;

    // register values as last written, used only to aim requests at thresholds
    logic        en_now;
    logic [14:0] torque_lim_now;
    logic [15:0] stall_now;
    logic [15:0] interval_now;

    int requests_sent;
    int useful_sent;     // requests with a defined kind
    int reg_writes;
    int burst_left;      // requests left in the current sender burst
    int max_gap;         // longest sender gap in the current phase

    brake_hold_diag_sequencer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    bhds_result_monitor result_mon (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .frames_seen  (frames_seen)
    );

    // 12 ns clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // hard limit, far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("timeout with %0d results still outstanding", pending);
        $display("brake_hold_diag_sequencer_core_tb failed");
        $finish;
    end

    // result receiver: switches between randomly picked stall styles, including open
    // stretches with no stalls at all
    initial begin : ready_pattern
        rx_style_t style;
        int        left;
        int        step;
        m_tready = 1'b0;
        style    = RX_OPEN;
        left     = 0;
        step     = 0;
        forever begin
            @(negedge aclk);
            if (left == 0) begin
                style = rx_style_t'($urandom_range(0, 3));
                left  = $urandom_range(40, 300);
            end
            left--;
            step++;
            case (style)
                RX_OPEN:   m_tready = 1'b1;
                RX_COIN:   m_tready = 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready = ($urandom_range(0, 5) == 0);
                default:   m_tready = (step % 8) < 3;
            endcase
        end
    end

    function automatic bhds_pkg::item_t build_request(input logic [2:0] kind,
                                                      input logic stopped,
                                                      input logic dyno,
                                                      input logic [15:0] rpm,
                                                      input logic [15:0] torque,
                                                      input logic [31:0] now);
        bhds_pkg::item_t ev;
        ev.kind            = kind;
        ev.vehicle_stopped = stopped;
        ev.dyno_mode       = dyno;
        ev.engine_rpm      = rpm;
        ev.torque_value    = torque;
        ev.time_now        = now;
        return ev;
    endfunction

    // one request on the event stream; bursts with random gaps in between
    task automatic send_event(input bhds_pkg::item_t ev);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, max_gap)) @(negedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tuser  = ev.kind;
        s_tdata  = {6'd0, ev.time_now, ev.torque_value, ev.engine_rpm,
                    ev.dyno_mode, ev.vehicle_stopped};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        // the next request, if any, raises valid again in this same step
        s_tvalid = 1'b0;
        requests_sent++;
        if (ev.kind <= bhds_pkg::KIND_LAUNCH)
            useful_sent++;
    endtask

    task automatic write_reg(input logic [bhds_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [bhds_pkg::CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_addr  = idx;
        cfg_data  = data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
        reg_writes++;
        case (idx)
            bhds_pkg::CFG_IDX_ENABLE:   en_now         = data[0];
            bhds_pkg::CFG_IDX_TORQUE:   torque_lim_now = data[14:0];
            bhds_pkg::CFG_IDX_STALL:    stall_now      = data;
            bhds_pkg::CFG_IDX_INTERVAL: interval_now   = data;
            default: ;
        endcase
    endtask

    // hold off until every outstanding result is back
    task automatic settle();
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // a full register setting; the spare upper bits of the enable write get
    // random filler so the register width is exercised
    task automatic apply_settings(input logic en, input logic [15:0] torque_raw,
                                  input logic [15:0] stall, input logic [15:0] interval);
        settle();
        write_reg(bhds_pkg::CFG_IDX_ENABLE, {15'($urandom), en});
        write_reg(bhds_pkg::CFG_IDX_TORQUE, torque_raw);
        write_reg(bhds_pkg::CFG_IDX_STALL, stall);
        write_reg(bhds_pkg::CFG_IDX_INTERVAL, interval);
    endtask

    // time advance between ticks: early, exactly on the interval, just past
    // it, comfortably past it, or anywhere in the wrapping range
    function automatic logic [31:0] tick_step();
        logic [31:0] gap;
        case ($urandom_range(0, 5))
            0:       gap = $urandom_range(0, interval_now);
            1:       gap = 32'(interval_now);
            2:       gap = 32'(interval_now) + 32'd1;
            3, 4:    gap = 32'(interval_now) + $urandom_range(1, 3000);
            default: gap = $urandom;
        endcase
        return gap;
    endfunction

    // torque a few newton metres either side of the launch limit, or anything
    function automatic logic [15:0] torque_near_limit();
        int v;
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        v = int'(torque_lim_now) + int'($urandom_range(0, 6)) - 3;
        return 16'(v);
    endfunction

    // rpm anywhere below the stall limit, or at and a little above it
    function automatic logic [15:0] rpm_near_stall(input logic below);
        int v;
        if (below && stall_now != 0)
            return 16'($urandom_range(0, int'(stall_now) - 1));
        v = int'(stall_now) + int'($urandom_range(0, 40));
        return (v > 65535) ? 16'hFFFF : 16'(v);
    endfunction

    // force, a run of ticks, launch queries, rpm reports and repeat forces, then
    // usually a release or a stall followed by ticks to send the release frame
    task automatic run_hold_sequence();
        logic [31:0] t_ms;
        int          pick;
        t_ms = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 4000)
                                           : $urandom;
        send_event(build_request(bhds_pkg::KIND_FORCE, $urandom_range(0, 11) != 0,
                                 $urandom_range(0, 11) != 0, 16'($urandom),
                                 16'($urandom), $urandom));
        repeat ($urandom_range(3, 14)) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                t_ms = t_ms + tick_step();
                send_event(build_request(bhds_pkg::KIND_TICK, 1'($urandom), 1'($urandom),
                                         16'($urandom), 16'($urandom), t_ms));
            end else if (pick < 75) begin
                send_event(build_request(bhds_pkg::KIND_LAUNCH, 1'($urandom),
                                         1'($urandom), 16'($urandom),
                                         torque_near_limit(), $urandom));
            end else if (pick < 93) begin
                send_event(build_request(bhds_pkg::KIND_RPM, 1'($urandom), 1'($urandom),
                                         rpm_near_stall($urandom_range(0, 4) == 0),
                                         16'($urandom), $urandom));
            end else begin
                send_event(build_request(bhds_pkg::KIND_FORCE, 1'b1, 1'b1, 16'($urandom),
                                         16'($urandom), $urandom));
            end
        end
        pick = $urandom_range(0, 99);
        if (pick < 45)
            send_event(build_request(bhds_pkg::KIND_RELEASE, 1'($urandom), 1'($urandom),
                                     16'($urandom), 16'($urandom), $urandom));
        else if (pick < 85)
            send_event(build_request(bhds_pkg::KIND_RPM, 1'($urandom), 1'($urandom),
                                     rpm_near_stall(1'b1), 16'($urandom), $urandom));
        repeat ($urandom_range(1, 3)) begin
            t_ms = t_ms + tick_step();
            send_event(build_request(bhds_pkg::KIND_TICK, 1'($urandom), 1'($urandom),
                                     16'($urandom), 16'($urandom), t_ms));
        end
    endtask

    initial begin : stimulus
        int goal;
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_addr       = '0;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        en_now         = 1'b0;
        torque_lim_now = bhds_pkg::TORQUE_LIMIT_RESET;
        stall_now      = bhds_pkg::STALL_RPM_RESET;
        interval_now   = bhds_pkg::INTERVAL_RESET;
        requests_sent  = 0;
        useful_sent    = 0;
        reg_writes     = 0;
        burst_left     = 0;
        max_gap        = 0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // --- directed part, registers at their reset values (disabled) ---
        // force refused while the feature is off
        send_event(build_request(bhds_pkg::KIND_FORCE, 1'b1, 1'b1, '0, '0, '0));
        // tick while disabled and idle: no frame
        send_event(build_request(bhds_pkg::KIND_TICK, 1'b0, 1'b0, '0, '0, 32'd100));
        // undefined kinds with every field at its maximum: all-zero result
        for (int k = int'(bhds_pkg::KIND_LAUNCH) + 1; k < (1 << $bits(s_tuser)); k++)
            send_event(build_request(3'(k), 1'b1, 1'b1, 16'hFFFF, 16'hFFFF,
                                     32'hFFFF_FFFF));
        settle();
        write_reg(bhds_pkg::CFG_IDX_ENABLE, 16'd1);

        // force needs both a stopped vehicle and dyno mode
        send_event(build_request(bhds_pkg::KIND_FORCE, 1'b0, 1'b1, '0, '0, '0));
        send_event(build_request(bhds_pkg::KIND_FORCE, 1'b1, 1'b0, '0, '0, '0));
        // release and stall ignored while idle
        send_event(build_request(bhds_pkg::KIND_RELEASE, 1'b0, 1'b0, '0, '0, '0));
        send_event(build_request(bhds_pkg::KIND_RPM, 1'b0, 1'b0, '0, '0, '0));
        // hold starts, a second force is ignored
        send_event(build_request(bhds_pkg::KIND_FORCE, 1'b1, 1'b1, '0, '0, '0));
        send_event(build_request(bhds_pkg::KIND_FORCE, 1'b1, 1'b1, '0, '0, '0));
        // launch query just below, at, and far below the limit
        send_event(build_request(bhds_pkg::KIND_LAUNCH, 1'b0, 1'b0, '0, 16'd99, '0));
        send_event(build_request(bhds_pkg::KIND_LAUNCH, 1'b0, 1'b0, '0, 16'd100, '0));
        send_event(build_request(bhds_pkg::KIND_LAUNCH, 1'b0, 1'b0, '0, 16'h8000, '0));
        // session frame at once, then pacing: exactly on the interval is too
        // early, one past it sends; tester and io alternate
        send_event(build_request(bhds_pkg::KIND_TICK, 1'b0, 1'b0, '0, '0, 32'd1000));
        send_event(build_request(bhds_pkg::KIND_TICK, 1'b0, 1'b0, '0, '0, 32'd1500));
        send_event(build_request(bhds_pkg::KIND_TICK, 1'b0, 1'b0, '0, '0, 32'd1501));
        send_event(build_request(bhds_pkg::KIND_TICK, 1'b0, 1'b0, '0, '0, 32'd2002));
        send_event(build_request(bhds_pkg::KIND_TICK, 1'b0, 1'b0, '0, '0, 32'd2503));
        // rpm at the stall limit holds, one below releases
        send_event(build_request(bhds_pkg::KIND_RPM, 1'b0, 1'b0, 16'd400, '0, '0));
        send_event(build_request(bhds_pkg::KIND_RPM, 1'b0, 1'b0, 16'd399, '0, '0));
        // launch assist is gone after the release
        send_event(build_request(bhds_pkg::KIND_LAUNCH, 1'b0, 1'b0, '0, 16'h7FFF, '0));
        // release restarts pacing, so the release frame goes out right away
        send_event(build_request(bhds_pkg::KIND_TICK, 1'b0, 1'b0, '0, '0, 32'd2504));

        // --- random part, one register setting per phase ---
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: apply_settings(1'b1, 16'd100, 16'd400, 16'd500);
                1: apply_settings(1'b1, 16'd0, 16'd0, 16'd0);
                2: apply_settings(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: begin
                    apply_settings(1'b0, 16'($urandom), 16'($urandom),
                                   16'($urandom_range(0, 2000)));
                    // write to an index with no register behind it
                    write_reg(CFG_IDX_SPARE, 16'($urandom));
                end
                default: apply_settings(1'b1, 16'($urandom), 16'($urandom_range(0, 3000)),
                                        16'($urandom_range(0, 3000)));
            endcase
            // phases alternate between no gaps, short gaps and long gaps
            max_gap = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 4 : 14);
            goal = useful_sent + REQUEST_GOAL / PHASES;
            while (useful_sent < goal) begin
                if ($urandom_range(0, 99) < 80)
                    run_hold_sequence();
                else
                    send_event(build_request(3'($urandom), 1'($urandom), 1'($urandom),
                                             16'($urandom), 16'($urandom), $urandom));
            end
        end

        // drain and idle before the verdict
        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);

        $display("covered %0d requests (%0d with defined kinds), %0d results, %0d frames",
                 requests_sent, useful_sent, results_seen, frames_seen);
        $display("%0d register writes across %0d random settings incl. both extremes",
                 reg_writes, PHASES);
        if (fail_count == 0)
            $display("brake_hold_diag_sequencer_core_tb passed");
        else
            $display("brake_hold_diag_sequencer_core_tb failed");
        $finish;
    end

endmodule
